// File: rtl/multichannel_sensor_smoother_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor smoother core
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SENSOR_SMOOTHER_CORE_MACROS_SVH
`define MULTICHANNEL_SENSOR_SMOOTHER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define MSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define MSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// Sensor smoother package
// Field widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 2;
    localparam int GAIN_W     = 9;
    localparam int PCT_W      = 7;
    localparam int WRAP_W     = 8;
    localparam int ACC_W      = 32;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int PCT_SCALE  = 100;
    localparam int PCT_SHIFT  = 10;

    localparam logic [CHAN_W-1:0] CH_LIGHT   = 2'd2;
    localparam logic [CHAN_W-1:0] CH_INVALID = 2'd3;
    localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;

    localparam logic [GAIN_W-1:0] RST_SENSOR_GAIN   = 9'd160;
    localparam logic [GAIN_W-1:0] RST_LIGHT_GAIN    = 9'd4;
    localparam logic [PCT_W-1:0]  RST_LIGHT_OFFSET  = 7'd20;
    localparam logic [PCT_W-1:0]  RST_LED_ON_BELOW  = 7'd45;
    localparam logic [PCT_W-1:0]  RST_LED_OFF_ABOVE = 7'd55;
    localparam logic [WRAP_W-1:0] RST_REPORT_WRAP   = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_GAIN   = 3'd0,
        CFG_LIGHT_GAIN    = 3'd1,
        CFG_LIGHT_OFFSET  = 3'd2,
        CFG_LED_ON_BELOW  = 3'd3,
        CFG_LED_OFF_ABOVE = 3'd4,
        CFG_REPORT_WRAP   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FILT,
        ST_PCT,
        ST_PCT_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PCT_W-1:0]  light_offset;
        logic [PCT_W-1:0]  led_on_below;
        logic [PCT_W-1:0]  led_off_above;
        logic [WRAP_W-1:0] report_wrap;
    } t_batch_cfg;

    typedef struct packed {
        logic [PCT_W-1:0] light_pct;
        logic             led_on;
        logic             report_pulse;
    } t_batch_stat;

endpackage

// File: rtl/mss_if.sv
// ----------------------------------------------------------------------------
// Sensor smoother stream interfaces
// Valid/ready channels for samples in and filtered results out.
// ----------------------------------------------------------------------------
interface mss_in_if
    import mss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    logic                batch_last;

    modport source (output valid, output chan, output sample, output batch_last,
                    input ready);
    modport sink   (input valid, input chan, input sample, input batch_last,
                    output ready);
endinterface

interface mss_out_if
    import mss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   chan_out;
    logic [SAMPLE_W-1:0] smoothed;
    logic                batch_done;
    logic [PCT_W-1:0]    light_pct;
    logic                led_on;
    logic                report_pulse;

    modport source (output valid, output chan_out, output smoothed, output batch_done,
                    output light_pct, output led_on, output report_pulse,
                    input ready);
    modport sink   (input valid, input chan_out, input smoothed, input batch_done,
                    input light_pct, input led_on, input report_pulse,
                    output ready);
endinterface

// File: rtl/mss_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Takes one multiplier bit per cycle; the product is kept modulo 2^ACC_W.
// ----------------------------------------------------------------------------
module mss_serial_mul
    import mss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_mcand,
    input  logic [GAIN_W-1:0] i_mplier,
    output logic              o_busy,
    output logic [ACC_W-1:0]  o_prod
);

    logic [GAIN_W-1:0] r_mplier, n_mplier;
    logic [ACC_W-1:0]  r_mcand, n_mcand;
    logic [ACC_W-1:0]  r_prod, n_prod;

    always_comb begin
        n_mplier = r_mplier;
        n_mcand  = r_mcand;
        n_prod   = r_prod;
        if (i_start) begin
            n_mplier = i_mplier;
            n_mcand  = i_mcand;
            n_prod   = '0;
        end else if (r_mplier != '0) begin
            if (r_mplier[0]) begin
                n_prod = r_prod + r_mcand;
            end
            n_mcand  = {r_mcand[ACC_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[GAIN_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else begin
            r_mplier <= n_mplier;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
    end

    // The run ends as soon as no set multiplier bit is left.
    assign o_busy = (r_mplier != '0);
    assign o_prod = r_prod;

endmodule

// File: rtl/mss_batch_ctl.sv
// ----------------------------------------------------------------------------
// Batch-end control
// Light percent with offset and clamp, LED hysteresis and report counter.
// ----------------------------------------------------------------------------
module mss_batch_ctl
    import mss_pkg::*;
#(
    parameter int Q_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_update,
    input  logic [Q_BITS-1:0] i_level,
    input  t_batch_cfg        i_cfg,
    output t_batch_stat       o_stat
);

    localparam int CW = ((Q_BITS > PCT_W) ? Q_BITS : PCT_W) + 1;

    logic [PCT_W-1:0]  r_pct, n_pct;
    logic              r_led, n_led;
    logic [WRAP_W-1:0] r_cnt, n_cnt;
    logic              r_pulse, n_pulse;
    logic [CW-1:0]     w_level;
    logic [CW-1:0]     w_offset;
    logic [CW-1:0]     w_diff;

    assign w_level  = CW'(i_level);
    assign w_offset = CW'(i_cfg.light_offset);
    assign w_diff   = w_level - w_offset;

    always_comb begin
        n_pct   = r_pct;
        n_led   = r_led;
        n_cnt   = r_cnt;
        n_pulse = r_pulse;
        if (i_update) begin
            if (w_level <= w_offset) begin
                n_pct = '0;
            end else if (w_diff > CW'(PCT_MAX)) begin
                n_pct = PCT_MAX;
            end else begin
                n_pct = w_diff[PCT_W-1:0];
            end
            // The turn-on test is checked first, so it wins on crossed thresholds.
            if (n_pct < i_cfg.led_on_below) begin
                n_led = 1'b1;
            end else if (n_pct > i_cfg.led_off_above) begin
                n_led = 1'b0;
            end
            if (r_cnt == i_cfg.report_wrap) begin
                n_pulse = 1'b1;
                n_cnt   = '0;
            end else begin
                n_pulse = 1'b0;
                n_cnt   = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct   <= '0;
            r_led   <= 1'b0;
            r_cnt   <= '0;
            r_pulse <= 1'b0;
        end else begin
            r_pct   <= n_pct;
            r_led   <= n_led;
            r_cnt   <= n_cnt;
            r_pulse <= n_pulse;
        end
    end

    assign o_stat.light_pct    = r_pct;
    assign o_stat.led_on       = r_led;
    assign o_stat.report_pulse = r_pulse;

endmodule

// File: rtl/multichannel_sensor_smoother_core.sv
// ----------------------------------------------------------------------------
// Multichannel sensor smoother core
// Exponential moving average over three tagged channels with light percent,
// LED hysteresis and a periodic report pulse.
// ----------------------------------------------------------------------------
// One item is handled at a time. A channel's first sample and an invalid
// channel go from ST_EVAL straight to ST_DONE, where the output register
// loads, and the next item is taken once the core is back in ST_IDLE. A
// filter update passes ST_EVAL, then waits in ST_FILT on the gain multiply,
// which runs one gain bit per cycle in a shared shift-add multiplier up to
// the highest set bit of the channel's gain. The last item of a batch also
// passes ST_PCT and ST_PCT_WAIT, in which the same multiplier forms
// light * 100 over 7 bits. While a result waits in the output register the
// next item is taken; that item then holds its result until the register
// drains, and the input stays closed meanwhile.
`include "multichannel_sensor_smoother_core_macros.svh"

module multichannel_sensor_smoother_core
    import mss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mss_in_if.sink                i_in,
    mss_out_if.source             o_out
);

    localparam int DIFF_W = ACC_W + 1;
    localparam int RND_W  = ACC_W - FRAC_BITS + 1;
    localparam int Q_BITS = SAMPLE_BITS - 4;
    localparam logic signed [RND_W-1:0] SAT_HI =
        (RND_W'(1) <<< (SAMPLE_BITS - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_sensor_gain, r_light_gain;
    t_batch_cfg        r_bcfg;

    logic [CHAN_W-1:0]      r_chan;
    logic [SAMPLE_BITS-1:0] r_s;
    logic                   r_last;
    logic [ACC_W-1:0]       r_acc [NUM_CH];
    logic [NUM_CH-1:0]      r_primed, n_primed;
    logic [SAMPLE_BITS-1:0] r_light, n_light;
    logic [SAMPLE_BITS-1:0] r_y, n_y;

    logic                r_out_valid, n_out_valid;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [SAMPLE_W-1:0] r_out_y;
    logic                r_out_last;
    logic [PCT_W-1:0]    r_out_pct;
    logic                r_out_led;
    logic                r_out_pulse;

    logic                    w_accept;
    logic                    w_out_load;
    logic [ACC_W-1:0]        w_acc_sel;
    logic [DIFF_W-1:0]       w_diff;
    logic [ACC_W-1:0]        w_na;
    logic signed [RND_W-1:0] w_round;
    logic [SAMPLE_BITS-1:0]  w_y_sat;
    logic                    w_acc_we;
    logic [ACC_W-1:0]        w_acc_wdata;

    logic              w_mul_start;
    logic [ACC_W-1:0]  w_mul_mcand;
    logic [GAIN_W-1:0] w_mul_mplier;
    logic              w_mul_busy;
    logic [ACC_W-1:0]  w_mul_prod;

    logic        w_batch_update;
    t_batch_stat w_bstat;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_gain        <= RST_SENSOR_GAIN;
            r_light_gain         <= RST_LIGHT_GAIN;
            r_bcfg.light_offset  <= RST_LIGHT_OFFSET;
            r_bcfg.led_on_below  <= RST_LED_ON_BELOW;
            r_bcfg.led_off_above <= RST_LED_OFF_ABOVE;
            r_bcfg.report_wrap   <= RST_REPORT_WRAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SENSOR_GAIN:   r_sensor_gain        <= i_cfg_data;
                CFG_LIGHT_GAIN:    r_light_gain         <= i_cfg_data;
                CFG_LIGHT_OFFSET:  r_bcfg.light_offset  <= i_cfg_data[PCT_W-1:0];
                CFG_LED_ON_BELOW:  r_bcfg.led_on_below  <= i_cfg_data[PCT_W-1:0];
                CFG_LED_OFF_ABOVE: r_bcfg.led_off_above <= i_cfg_data[PCT_W-1:0];
                CFG_REPORT_WRAP:   r_bcfg.report_wrap   <= i_cfg_data[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- filter datapath ----------------
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign w_acc_sel = (r_chan == CH_INVALID) ? '0 : r_acc[r_chan];

    // floor((s * 256 - acc) / 256) is the arithmetic shift of the difference.
    assign w_diff = DIFF_W'($signed({r_s, {FRAC_BITS{1'b0}}})) - DIFF_W'($signed(w_acc_sel));
    assign w_na   = w_acc_sel + w_mul_prod;

    // Floor of the new accumulator over 256, rounded up by fraction bit 7.
    assign w_round = $signed({w_na[ACC_W-1], w_na[ACC_W-1:FRAC_BITS]})
                   + $signed({{(RND_W-1){1'b0}}, w_na[FRAC_BITS-1]});

    always_comb begin
        if (w_round > SAT_HI) begin
            w_y_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_round < SAT_LO) begin
            w_y_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_y_sat = w_round[SAMPLE_BITS-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state        = r_state;
        n_primed       = r_primed;
        n_light        = r_light;
        n_y            = r_y;
        w_acc_we       = 1'b0;
        w_acc_wdata    = w_na;
        w_mul_start    = 1'b0;
        w_mul_mcand    = ACC_W'($signed(w_diff[DIFF_W-1:FRAC_BITS]));
        w_mul_mplier   = (r_chan == CH_LIGHT) ? r_light_gain : r_sensor_gain;
        w_batch_update = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_chan == CH_INVALID) begin
                    n_y     = '0;
                    n_state = r_last ? ST_PCT : ST_DONE;
                end else if (!r_primed[r_chan]) begin
                    // First sample of a channel loads the accumulator directly.
                    w_acc_we    = 1'b1;
                    w_acc_wdata = ACC_W'($signed({r_s, {FRAC_BITS{1'b0}}}));
                    n_primed[r_chan] = 1'b1;
                    n_y = r_s;
                    if (r_chan == CH_LIGHT) begin
                        n_light = r_s;
                    end
                    n_state = r_last ? ST_PCT : ST_DONE;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = ST_FILT;
                end
            end
            ST_FILT: begin
                if (!w_mul_busy) begin
                    w_acc_we = 1'b1;
                    n_y      = w_y_sat;
                    if (r_chan == CH_LIGHT) begin
                        n_light = w_y_sat;
                    end
                    n_state = r_last ? ST_PCT : ST_DONE;
                end
            end
            ST_PCT: begin
                // A negative light value counts as zero.
                w_mul_start  = 1'b1;
                w_mul_mcand  = r_light[SAMPLE_BITS-1] ? '0
                                                      : ACC_W'(r_light[SAMPLE_BITS-2:0]);
                w_mul_mplier = GAIN_W'(PCT_SCALE);
                n_state      = ST_PCT_WAIT;
            end
            ST_PCT_WAIT: begin
                if (!w_mul_busy) begin
                    w_batch_update = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= '0;
            r_light     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_light     <= n_light;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_acc[i] <= '0;
            end
        end else if (w_acc_we) begin
            r_acc[r_chan] <= w_acc_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chan <= i_in.chan;
            r_s    <= i_in.sample[SAMPLE_BITS-1:0];
            r_last <= i_in.batch_last;
        end
        r_y <= n_y;
        if (w_out_load) begin
            r_out_chan  <= r_chan;
            r_out_y     <= SAMPLE_W'($signed(r_y));
            r_out_last  <= r_last;
            r_out_pct   <= w_bstat.light_pct;
            r_out_led   <= w_bstat.led_on;
            r_out_pulse <= r_last && w_bstat.report_pulse;
        end
    end

    // ---------------- submodules ----------------
    mss_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mul_mcand),
        .i_mplier (w_mul_mplier),
        .o_busy   (w_mul_busy),
        .o_prod   (w_mul_prod)
    );

    mss_batch_ctl #(
        .Q_BITS (Q_BITS)
    ) u_batch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_batch_update),
        .i_level  (w_mul_prod[PCT_SHIFT +: Q_BITS]),
        .i_cfg    (r_bcfg),
        .o_stat   (w_bstat)
    );

    // ---------------- ports ----------------
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.chan_out      = r_out_chan;
    assign o_out.smoothed      = r_out_y;
    assign o_out.batch_done    = r_out_last;
    assign o_out.light_pct     = r_out_pct;
    assign o_out.led_on        = r_out_led;
    assign o_out.report_pulse  = r_out_pulse;

    // ---------------- assertions ----------------
    `MSS_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, w_accept, r_state == ST_EVAL)
    `MSS_ASSERT_IMP(a_mul_free, i_clk, i_rst_n, w_mul_start, !w_mul_busy)
    `MSS_ASSERT_IMP(a_pulse_batch, i_clk, i_rst_n, o_out.valid && o_out.report_pulse, o_out.batch_done)
    `MSS_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_out.valid && (o_out.chan_out == CH_INVALID), o_out.smoothed == '0)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor smoother core testbench
// Drives tagged samples through the valid/ready input stream and checks every
// filtered result against a cycle-free model of the smoother. The filter
// state, light percent, LED hysteresis and report counter are all modeled.
// Directed items cover the reset defaults and the register extremes. A long
// report-counter run, an output hold-off and randomized traffic under
// random register settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import mss_pkg::*;

    localparam int MAX_IDLE        = 17;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_REPORTS     = 100;
    localparam int RANDOM_PHASES   = 9;
    localparam int PHASE_ITEMS     = 115;
    localparam int NUM_CFG_REGS    = int'(CFG_REPORT_WRAP) + 1;

    localparam logic [CHAN_W-1:0] CH_REF   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_THERM = 2'd1;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] sample;
        logic                batch_last;
    } sample_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan_out;
        logic [SAMPLE_W-1:0] smoothed;
        logic                batch_done;
        logic [PCT_W-1:0]    light_pct;
        logic                led_on;
        logic                report_pulse;
    } smooth_result_t;

    typedef logic [NUM_CFG_REGS-1:0][CFG_DATA_W-1:0] cfg_vals_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mss_in_if  in_ch ();
    mss_out_if out_ch ();

    multichannel_sensor_smoother_core #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the filter state and the registers, updated as items are accepted.
    logic [ACC_W-1:0]           model_acc [NUM_CH] = '{default: '0};
    logic                       model_primed [NUM_CH] = '{default: 1'b0};
    logic signed [SAMPLE_W-1:0] model_light = '0;
    logic [PCT_W-1:0]           model_pct = '0;
    logic                       model_led = 1'b0;
    logic [WRAP_W-1:0]          model_batches = '0;
    logic [GAIN_W-1:0]          m_sensor_gain = RST_SENSOR_GAIN;
    logic [GAIN_W-1:0]          m_light_gain = RST_LIGHT_GAIN;
    logic [PCT_W-1:0]           m_light_offset = RST_LIGHT_OFFSET;
    logic [PCT_W-1:0]           m_on_below = RST_LED_ON_BELOW;
    logic [PCT_W-1:0]           m_off_above = RST_LED_OFF_ABOVE;
    logic [WRAP_W-1:0]          m_report_wrap = RST_REPORT_WRAP;

    smooth_result_t      expected_results [$];
    logic [SAMPLE_W-1:0] recent_sample [NUM_CH + 1] = '{default: '0};
    int                  error_count = 0;
    int                  result_count = 0;
    int                  quiet_cycles = 0;
    logic                idle_in = 1'b1;
    logic                idle_out = 1'b1;
    logic                hold_req = 1'b0;

    function automatic smooth_result_t smooth_step(input sample_item_t it);
        longint         s;
        longint         acc;
        longint         gain;
        longint         upd;
        longint         nacc;
        longint         y;
        longint         lvl;
        logic [ACC_W-1:0] na;
        smooth_result_t r;
        s = longint'($signed(it.sample));
        y = 0;
        r.report_pulse = 1'b0;
        if (it.chan != CH_INVALID) begin
            if (!model_primed[it.chan]) begin
                model_acc[it.chan] = ACC_W'(s <<< FRAC_BITS);
                model_primed[it.chan] = 1'b1;
                y = s;
            end else begin
                acc = longint'($signed(model_acc[it.chan]));
                gain = (it.chan == CH_LIGHT) ? longint'(m_light_gain) : longint'(m_sensor_gain);
                upd = (((s <<< FRAC_BITS) - acc) >>> FRAC_BITS) * gain;
                na = ACC_W'(acc + upd);
                nacc = longint'($signed(na));
                // Bit 7 of the accumulator rounds the output to nearest.
                y = (nacc >>> FRAC_BITS) + longint'(na[FRAC_BITS-1]);
                model_acc[it.chan] = na;
            end
            if (y > SAMPLE_MAX) begin
                y = SAMPLE_MAX;
            end else if (y < SAMPLE_MIN) begin
                y = SAMPLE_MIN;
            end
            if (it.chan == CH_LIGHT) begin
                model_light = SAMPLE_W'(y);
            end
        end
        if (it.batch_last) begin
            lvl = (model_light < 0) ? 0 : longint'(model_light);
            lvl = ((lvl * PCT_SCALE) >>> PCT_SHIFT) - longint'(m_light_offset);
            if (lvl > longint'(PCT_MAX)) begin
                lvl = longint'(PCT_MAX);
            end else if (lvl < 0) begin
                lvl = 0;
            end
            model_pct = PCT_W'(lvl);
            // The turn-on test takes priority when the thresholds cross.
            if (model_pct < m_on_below) begin
                model_led = 1'b1;
            end else if (model_pct > m_off_above) begin
                model_led = 1'b0;
            end
            if (model_batches == m_report_wrap) begin
                r.report_pulse = 1'b1;
                model_batches = '0;
            end else begin
                model_batches = model_batches + 1'b1;
            end
        end
        r.chan_out = it.chan;
        r.smoothed = SAMPLE_W'(y);
        r.batch_done = it.batch_last;
        r.light_pct = model_pct;
        r.led_on = model_led;
        return r;
    endfunction

    function automatic cfg_vals_t random_cfg();
        cfg_vals_t v;
        for (int i = 0; i < NUM_CFG_REGS; i++) begin
            v[i] = CFG_DATA_W'($urandom());
        end
        case ($urandom_range(0, 4))
            0: v[CFG_SENSOR_GAIN] = 9'd0;
            1: v[CFG_SENSOR_GAIN] = 9'd256;
            2: v[CFG_SENSOR_GAIN] = 9'd511;
            default: v[CFG_SENSOR_GAIN] = CFG_DATA_W'($urandom_range(1, 256));
        endcase
        case ($urandom_range(0, 4))
            0: v[CFG_LIGHT_GAIN] = 9'd0;
            1: v[CFG_LIGHT_GAIN] = 9'd256;
            2: v[CFG_LIGHT_GAIN] = 9'd511;
            default: v[CFG_LIGHT_GAIN] = CFG_DATA_W'($urandom_range(1, 256));
        endcase
        // Mostly in-range percents, with the raw random data now and then.
        if ($urandom_range(0, 3) != 0) begin
            v[CFG_LIGHT_OFFSET] = CFG_DATA_W'($urandom_range(0, 100));
            v[CFG_LED_ON_BELOW] = CFG_DATA_W'($urandom_range(0, 100));
            v[CFG_LED_OFF_ABOVE] = CFG_DATA_W'($urandom_range(0, 100));
        end
        if ($urandom_range(0, 3) != 0) begin
            v[CFG_REPORT_WRAP] = CFG_DATA_W'($urandom_range(0, 7));
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("MISMATCH result %0d at %0t: %s", result_count, $realtime, what);
        end
        error_count++;
    endtask

    task automatic check_result();
        smooth_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no item pending");
        end else begin
            want = expected_results.pop_front();
            if (out_ch.chan_out !== want.chan_out) begin
                report_mismatch($sformatf("chan_out %0d, expected %0d",
                                          out_ch.chan_out, want.chan_out));
            end
            if (out_ch.smoothed !== want.smoothed) begin
                report_mismatch($sformatf("smoothed %0d, expected %0d",
                                          $signed(out_ch.smoothed), $signed(want.smoothed)));
            end
            if (out_ch.batch_done !== want.batch_done) begin
                report_mismatch($sformatf("batch_done %0b, expected %0b",
                                          out_ch.batch_done, want.batch_done));
            end
            if (out_ch.light_pct !== want.light_pct) begin
                report_mismatch($sformatf("light_pct %0d, expected %0d",
                                          out_ch.light_pct, want.light_pct));
            end
            if (out_ch.led_on !== want.led_on) begin
                report_mismatch($sformatf("led_on %0b, expected %0b",
                                          out_ch.led_on, want.led_on));
            end
            if (out_ch.report_pulse !== want.report_pulse) begin
                report_mismatch($sformatf("report_pulse %0b, expected %0b",
                                          out_ch.report_pulse, want.report_pulse));
            end
        end
        result_count++;
    endtask

    // Valid is left high after an item is accepted so that back-to-back items
    // need no second assignment in the same step; the next gap or the drain
    // lowers it.
    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_W-1:0] value,
                               input logic last);
        int           gap;
        sample_item_t it;
        gap = idle_in ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.chan <= chan;
        in_ch.sample <= value;
        in_ch.batch_last <= last;
        it.chan = chan;
        it.sample = value;
        it.batch_last = last;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        expected_results.push_back(smooth_step(it));
    endtask

    task automatic send_random(input logic force_last);
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] v;
        int                  pick;
        ch = ($urandom_range(0, 99) < 8) ? CH_INVALID : CHAN_W'($urandom_range(0, NUM_CH - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = 16'h0000;
                default: v = 16'hFFFF;
            endcase
        end else if (pick <= 3) begin
            v = SAMPLE_W'($urandom());
        end else if (ch == CH_LIGHT) begin
            // This span maps onto the whole percent scale for common offsets.
            v = SAMPLE_W'($urandom_range(0, 2400));
        end else begin
            v = recent_sample[ch] + SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
        end
        recent_sample[ch] = v;
        send_sample(ch, v, force_last || ($urandom_range(0, 3) == 0));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SENSOR_GAIN:   m_sensor_gain = data[GAIN_W-1:0];
            CFG_LIGHT_GAIN:    m_light_gain = data[GAIN_W-1:0];
            CFG_LIGHT_OFFSET:  m_light_offset = data[PCT_W-1:0];
            CFG_LED_ON_BELOW:  m_on_below = data[PCT_W-1:0];
            CFG_LED_OFF_ABOVE: m_off_above = data[PCT_W-1:0];
            CFG_REPORT_WRAP:   m_report_wrap = data[WRAP_W-1:0];
            default: ;
        endcase
    endtask

    // Writes every register, then one index past the list that must be ignored.
    task automatic apply_config(input cfg_vals_t v);
        for (int i = 0; i < NUM_CFG_REGS; i++) begin
            write_reg(CFG_IDX_W'(i), v[i]);
        end
        write_reg(CFG_IDX_W'(NUM_CFG_REGS + $urandom_range(0, 1)), CFG_DATA_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        idle_in = 1'b1;
        idle_out = 1'b1;
        send_sample(CH_INVALID, 16'h1234, 1'b0);
        send_sample(CH_REF, 16'h8000, 1'b0);
        send_sample(CH_THERM, 16'h7FFF, 1'b0);
        send_sample(CH_LIGHT, 16'd1500, 1'b1);
        send_sample(CH_REF, 16'h7FFF, 1'b0);
        send_sample(CH_REF, 16'h7FFF, 1'b0);
        send_sample(CH_THERM, 16'h8000, 1'b0);
        send_sample(CH_THERM, 16'h0001, 1'b0);
        send_sample(CH_LIGHT, 16'd200, 1'b1);
        send_sample(CH_INVALID, 16'hFFFF, 1'b1);
        send_sample(CH_REF, 16'h0000, 1'b1);
        send_sample(CH_LIGHT, 16'hFFFF, 1'b1);
        send_sample(CH_INVALID, 16'h0000, 1'b1);
    endtask

    task automatic test_config_extremes();
        cfg_vals_t v;
        // Zero gains freeze the filters; crossed thresholds; report every batch.
        wait_drained();
        v = '0;
        v[CFG_LED_ON_BELOW] = 9'd100;
        apply_config(v);
        send_sample(CH_REF, 16'd1000, 1'b0);
        send_sample(CH_LIGHT, 16'd2000, 1'b1);
        send_sample(CH_INVALID, 16'h5A5A, 1'b1);
        // Gains beyond unity overshoot into saturation; wide data is masked.
        wait_drained();
        v[CFG_SENSOR_GAIN] = 9'h1FF;
        v[CFG_LIGHT_GAIN] = 9'h1FF;
        v[CFG_LIGHT_OFFSET] = 9'h1FF;
        v[CFG_LED_ON_BELOW] = 9'h180;
        v[CFG_LED_OFF_ABOVE] = 9'h07F;
        v[CFG_REPORT_WRAP] = 9'h1FF;
        apply_config(v);
        send_sample(CH_REF, 16'h7FFF, 1'b0);
        send_sample(CH_REF, 16'h8000, 1'b0);
        send_sample(CH_REF, 16'h7FFF, 1'b0);
        send_sample(CH_LIGHT, 16'h7FFF, 1'b1);
        send_sample(CH_THERM, 16'h8000, 1'b0);
        // Unity gain tracks the input; a negative light value reads as zero.
        wait_drained();
        v[CFG_SENSOR_GAIN] = 9'd256;
        v[CFG_LIGHT_GAIN] = 9'd256;
        v[CFG_LIGHT_OFFSET] = 9'd0;
        v[CFG_LED_ON_BELOW] = 9'd1;
        v[CFG_LED_OFF_ABOVE] = 9'd100;
        v[CFG_REPORT_WRAP] = 9'd1;
        apply_config(v);
        send_sample(CH_LIGHT, 16'hFC18, 1'b1);
        send_sample(CH_LIGHT, 16'd1023, 1'b1);
        send_sample(CH_THERM, 16'h0080, 1'b0);
    endtask

    // Runs the batch counter past the wrap value so that it rolls over at 256.
    task automatic test_report_counter_wrap();
        cfg_vals_t v;
        wait_drained();
        v = random_cfg();
        v[CFG_REPORT_WRAP] = 9'd255;
        apply_config(v);
        repeat (12) send_random(1'b1);
        wait_drained();
        v[CFG_REPORT_WRAP] = 9'd3;
        apply_config(v);
        repeat (260) send_random(1'b1);
    endtask

    task automatic test_backpressure();
        wait_drained();
        idle_in = 1'b0;
        idle_out = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random(1'b0);
        idle_in = 1'b1;
        idle_out = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            apply_config(random_cfg());
            idle_in = (phase % 4 != 1) && (phase % 4 != 3);
            idle_out = (phase % 4 != 2) && (phase % 4 != 3);
            repeat (PHASE_ITEMS) send_random(1'b0);
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_out ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            check_result();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.chan <= '0;
        in_ch.sample <= '0;
        in_ch.batch_last <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_report_counter_wrap();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
